// File: design/bqt_pkg.sv
// ----------------------------------------------------------------------------
// bqt_pkg
// Shared types and codes of the broadcast quorum tracker.
// ----------------------------------------------------------------------------
package bqt_pkg;

  // message kinds carried in tuser
  localparam logic CMD_INIT       = 1'b0;
  localparam logic CMD_ECHO_READY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_NODE_COUNT    = 3'd0;
  localparam logic [2:0] CFG_FAULT_BOUND   = 3'd1;
  localparam logic [2:0] CFG_OWN_ID        = 3'd2;
  localparam logic [2:0] CFG_TRACKED_COUNT = 3'd3;
  localparam logic [2:0] CFG_BLOCK_COUNT   = 3'd4;

  typedef struct packed {
    logic [3:0] node_count;
    logic [2:0] fault_bound;
    logic [3:0] own_id;
    logic [3:0] tracked_count;
    logic [3:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [3:0] sender_id;
    logic       signature_ok;
    logic [2:0] block_index;
    logic [7:0] init_ack_bits;
    logic [7:0] echo_ack_bits;
    logic [7:0] echo_vote_bits;
    logic [7:0] ready_ack_bits;
    logic [7:0] ready_vote_bits;
    logic [7:0] digest_match_bits;
  } msg_t;

  typedef struct packed {
    logic       accepted;
    logic       want_init_reply;
    logic       want_er_reply;
    logic [7:0] init_flags;
    logic [7:0] echo_flags;
    logic [7:0] ready_flags;
    logic [7:0] echo_quorum_flags;
    logic [7:0] ready_quorum_flags;
    logic [7:0] done_flags;
    logic [3:0] done_total;
    logic       all_tracked_done;
  } result_t;

endpackage

// File: design/bqt_core.sv
// ----------------------------------------------------------------------------
// bqt_core
// Per-proposer vote state and its combinational update for one message.
// ----------------------------------------------------------------------------
module bqt_core
  import bqt_pkg::*;
#(
  parameter int NODE_LIMIT = 8,
  parameter int MAX_BLOCKS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  msg_t    msg,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [3:0] CNT_MAX  = 4'd15;
  localparam logic [1:0] ECHO_BONUS = 2'd2;

  logic [MAX_BLOCKS-1:0] block_seen      [NODE_LIMIT];
  logic [3:0]            blocks_received [NODE_LIMIT];
  logic [3:0]            echo_counts     [NODE_LIMIT];
  logic [3:0]            ready_counts    [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] echo_seen_from  [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] ready_seen_from [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] init_bits, echo_bits, ready_bits, done_bits;
  logic [3:0]            done_counter;

  logic [MAX_BLOCKS-1:0] block_seen_next      [NODE_LIMIT];
  logic [3:0]            blocks_received_next [NODE_LIMIT];
  logic [3:0]            echo_counts_next     [NODE_LIMIT];
  logic [3:0]            ready_counts_next    [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] echo_seen_from_next  [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] ready_seen_from_next [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] init_bits_next, echo_bits_next, ready_bits_next, done_bits_next;
  logic [3:0]            done_counter_next;

  logic [3:0]            n_eff, d_eff, nb, quorum, s_full, done_inc;
  logic                  own_ok, acc, is_init, is_er;
  logic [NODE_LIMIT-1:0] om, sb, track_mask, node_mask, eq, rq, done_set;
  logic [MAX_BLOCKS-1:0] blk_bit;
  logic [4:0]            done_sum;

  function automatic logic [3:0] sat_add(input logic [3:0] v, input logic [1:0] d);
    logic [4:0] s;
    s = {1'b0, v} + {3'b000, d};
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[3:0];
  endfunction

  always_comb begin
    n_eff  = (cfg.node_count > 4'(NODE_LIMIT)) ? 4'(NODE_LIMIT) : cfg.node_count;
    d_eff  = (cfg.tracked_count > 4'(NODE_LIMIT)) ? 4'(NODE_LIMIT) : cfg.tracked_count;
    nb     = (cfg.block_count > 4'(MAX_BLOCKS)) ? 4'(MAX_BLOCKS) : cfg.block_count;
    quorum = (n_eff > {1'b0, cfg.fault_bound}) ? n_eff - {1'b0, cfg.fault_bound} : 4'd0;
    own_ok = (cfg.own_id != 4'd0) && (cfg.own_id <= 4'(NODE_LIMIT));
    om     = own_ok ? (NODE_LIMIT'(1) << (cfg.own_id - 4'd1)) : '0;
    acc    = (msg.sender_id != 4'd0) && (msg.sender_id <= n_eff) && msg.signature_ok;
    s_full = msg.sender_id - 4'd1;
    sb     = NODE_LIMIT'(1) << s_full;
    blk_bit = MAX_BLOCKS'(1) << msg.block_index;
    is_init = acc && (msg.command == CMD_INIT);
    is_er   = acc && (msg.command == CMD_ECHO_READY);
    for (int k = 0; k < NODE_LIMIT; k++) begin
      track_mask[k] = (4'(k) < d_eff);
      node_mask[k]  = (4'(k) < n_eff);
    end
  end

  always_comb begin
    logic       new_blk, init_done, ev, rv, rset;
    logic [3:0] br, ec, rc;
    logic [1:0] incs;
    init_bits_next  = init_bits;
    echo_bits_next  = echo_bits;
    ready_bits_next = ready_bits;
    done_bits_next  = done_bits;
    for (int k = 0; k < NODE_LIMIT; k++) begin
      // init path: only the sender's own row moves
      new_blk = is_init && (s_full == 4'(k)) && ({1'b0, msg.block_index} < nb)
                && !(|(block_seen[k] & blk_bit));
      br        = blocks_received[k] + 4'd1;
      init_done = new_blk && (br == nb);
      block_seen_next[k]      = new_blk ? (block_seen[k] | blk_bit) : block_seen[k];
      blocks_received_next[k] = new_blk ? br : blocks_received[k];

      // votes for proposer k
      ev = is_er && track_mask[k] && msg.digest_match_bits[k] && msg.echo_vote_bits[k]
           && !(|(echo_seen_from[k] & sb));
      rv = is_er && track_mask[k] && msg.digest_match_bits[k] && msg.ready_vote_bits[k]
           && !(|(ready_seen_from[k] & sb));

      ec = echo_counts[k];
      if (init_done) ec = sat_add(ec, ECHO_BONUS);
      if (ev)        ec = sat_add(ec, 2'd1);
      echo_counts_next[k] = ec;
      echo_seen_from_next[k] = (init_done || ev) ? (echo_seen_from[k] | sb)
                                                 : echo_seen_from[k];

      rset = ev && (ec >= quorum) && !ready_bits[k];
      incs = {1'b0, rset} + {1'b0, rv};
      rc   = sat_add(ready_counts[k], incs);
      ready_counts_next[k]    = rc;
      ready_seen_from_next[k] = rv ? (ready_seen_from[k] | sb) : ready_seen_from[k];

      // counts only grow, so the final count decides delivery
      done_set[k] = (incs != 2'd0) && (rc >= quorum) && !done_bits[k];

      if (init_done) begin
        init_bits_next[k] = 1'b1;
        echo_bits_next[k] = 1'b1;
      end
      if (rset)        ready_bits_next[k] = 1'b1;
      if (done_set[k]) done_bits_next[k]  = 1'b1;

      eq[k] = node_mask[k] && (echo_counts_next[k] >= quorum);
      rq[k] = node_mask[k] && (ready_counts_next[k] >= quorum);
    end
  end

  always_comb begin
    done_inc = 4'd0;
    for (int k = 0; k < NODE_LIMIT; k++) begin
      done_inc = done_inc + {3'b000, done_set[k]};
    end
    done_sum = {1'b0, done_counter} + {1'b0, done_inc};
    done_counter_next = (done_sum > {1'b0, CNT_MAX}) ? CNT_MAX : done_sum[3:0];
  end

  always_comb begin
    result.accepted        = acc;
    result.want_init_reply = acc && own_ok && (cfg.own_id <= cfg.tracked_count)
                             && !(|(msg.init_ack_bits[NODE_LIMIT-1:0] & om));
    result.want_er_reply   = is_er && (|(track_mask &
                             ((~msg.echo_ack_bits[NODE_LIMIT-1:0] & (echo_bits | om)) |
                              (~msg.ready_ack_bits[NODE_LIMIT-1:0] & ready_bits))));
    result.init_flags         = 8'(init_bits_next | om);
    result.echo_flags         = 8'(echo_bits_next | om);
    result.ready_flags        = 8'(ready_bits_next);
    result.echo_quorum_flags  = 8'(eq);
    result.ready_quorum_flags = 8'(rq);
    result.done_flags         = 8'(done_bits_next);
    result.done_total         = done_counter_next;
    result.all_tracked_done   = (done_counter_next == cfg.tracked_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NODE_LIMIT; k++) begin
        block_seen[k]      <= '0;
        blocks_received[k] <= '0;
        echo_counts[k]     <= '0;
        ready_counts[k]    <= '0;
        echo_seen_from[k]  <= '0;
        ready_seen_from[k] <= '0;
      end
      init_bits    <= '0;
      echo_bits    <= '0;
      ready_bits   <= '0;
      done_bits    <= '0;
      done_counter <= '0;
    end else if (fire) begin
      for (int k = 0; k < NODE_LIMIT; k++) begin
        block_seen[k]      <= block_seen_next[k];
        blocks_received[k] <= blocks_received_next[k];
        echo_counts[k]     <= echo_counts_next[k];
        ready_counts[k]    <= ready_counts_next[k];
        echo_seen_from[k]  <= echo_seen_from_next[k];
        ready_seen_from[k] <= ready_seen_from_next[k];
      end
      init_bits    <= init_bits_next;
      echo_bits    <= echo_bits_next;
      ready_bits   <= ready_bits_next;
      done_bits    <= done_bits_next;
      done_counter <= done_counter_next;
    end
  end

endmodule

// File: design/broadcast_quorum_tracker_unit.sv
// ----------------------------------------------------------------------------
// broadcast_quorum_tracker_unit
// Reliable-broadcast vote bookkeeping: one parsed message in, one status out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata message fields, s_tuser command
//  m_*     | out | m_tvalid/m_tready  | m_tdata status fields
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One message per cycle while m_tready is high; m_tvalid rises as out_reg loads.
//  The message register feeds the vote update, which writes state and the
//  result register in the same cycle.
//  Stalls on m_tready hold the result and, once the message register is full,
//  drop s_tready. rst is synchronous and clears all vote state; config
//  returns to N=4, f=1, own id 1, three tracked proposers, one block.
// ----------------------------------------------------------------------------
module broadcast_quorum_tracker_unit
  import bqt_pkg::*;
#(
  parameter int NODE_LIMIT = 8,
  parameter int MAX_BLOCKS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sender_id[3:0], signature_ok[4], block_index[7:5], init_ack_bits[15:8],
  // echo_ack_bits[23:16], echo_vote_bits[31:24], ready_ack_bits[39:32],
  // ready_vote_bits[47:40], digest_match_bits[55:48]
  input  logic [55:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accepted[0], want_init_reply[1], want_er_reply[2], init_flags[10:3],
  // echo_flags[18:11], ready_flags[26:19], echo_quorum_flags[34:27],
  // ready_quorum_flags[42:35], done_flags[50:43], done_total[54:51],
  // all_tracked_done[55]
  output logic [55:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  cfg_t    cfg;
  msg_t    in_msg;
  logic    in_valid;
  logic    advance;
  result_t core_result;
  result_t out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count    <= 4'd4;
      cfg.fault_bound   <= 3'd1;
      cfg.own_id        <= 4'd1;
      cfg.tracked_count <= 4'd3;
      cfg.block_count   <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE_COUNT:    cfg.node_count    <= cfg_data;
        CFG_FAULT_BOUND:   cfg.fault_bound   <= cfg_data[2:0];
        CFG_OWN_ID:        cfg.own_id        <= cfg_data;
        CFG_TRACKED_COUNT: cfg.tracked_count <= cfg_data;
        CFG_BLOCK_COUNT:   cfg.block_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the held message whenever the result register can take it
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_msg.command           <= s_tuser;
      in_msg.sender_id         <= s_tdata[3:0];
      in_msg.signature_ok      <= s_tdata[4];
      in_msg.block_index       <= s_tdata[7:5];
      in_msg.init_ack_bits     <= s_tdata[15:8];
      in_msg.echo_ack_bits     <= s_tdata[23:16];
      in_msg.echo_vote_bits    <= s_tdata[31:24];
      in_msg.ready_ack_bits    <= s_tdata[39:32];
      in_msg.ready_vote_bits   <= s_tdata[47:40];
      in_msg.digest_match_bits <= s_tdata[55:48];
    end
  end

  bqt_core #(
    .NODE_LIMIT (NODE_LIMIT),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .msg    (in_msg),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= core_result;
    end
  end

  assign m_tdata = {out_reg.all_tracked_done, out_reg.done_total, out_reg.done_flags,
                    out_reg.ready_quorum_flags, out_reg.echo_quorum_flags,
                    out_reg.ready_flags, out_reg.echo_flags, out_reg.init_flags,
                    out_reg.want_er_reply, out_reg.want_init_reply, out_reg.accepted};

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed message produced no result");

  a_done_count_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(out_reg.done_flags) == 32'(out_reg.done_total)))
    else $error("done_total disagrees with done_flags");

  a_reject_no_reply: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_reg.accepted) |-> (!out_reg.want_init_reply && !out_reg.want_er_reply))
    else $error("reply requested for a rejected message");

endmodule

// File: bench/quorum_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quorum_check_pkg
// Status predictor and scoreboard for the broadcast quorum tracker bench.
// Keeps its own copy of the vote state and registers and queues one predicted
// status word per message transfer, in transfer order.
// ----------------------------------------------------------------------------
package quorum_check_pkg;
  import bqt_pkg::*;

  localparam int unsigned PEERS       = 8;
  localparam int unsigned PARTS       = 8;
  localparam int unsigned ECHO_BONUS  = 2;
  localparam int unsigned TALLY_TOP   = 15;
  localparam int          REPORT_MAX  = 10;

  class quorum_scoreboard;
    cfg_t       regs;
    bit [7:0]   parts_seen [PEERS];
    bit [3:0]   parts_got [PEERS];
    bit [7:0]   init_map, echo_map, ready_map, done_map;
    bit [3:0]   echo_tally [PEERS];
    bit [3:0]   ready_tally [PEERS];
    bit [7:0]   echo_from [PEERS];
    bit [7:0]   ready_from [PEERS];
    bit [3:0]   delivered;
    result_t    status_due [$];
    int         mismatches;
    int         status_seen;

    function new();
      regs.node_count    = 4'd4;
      regs.fault_bound   = 3'd1;
      regs.own_id        = 4'd1;
      regs.tracked_count = 4'd3;
      regs.block_count   = 4'd1;
      foreach (parts_seen[k]) begin
        parts_seen[k]  = '0;
        parts_got[k]   = '0;
        echo_tally[k]  = '0;
        ready_tally[k] = '0;
        echo_from[k]   = '0;
        ready_from[k]  = '0;
      end
      init_map    = '0;
      echo_map    = '0;
      ready_map   = '0;
      done_map    = '0;
      delivered   = '0;
      mismatches  = 0;
      status_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [3:0] val);
      case (idx)
        CFG_NODE_COUNT:    regs.node_count    = val;
        CFG_FAULT_BOUND:   regs.fault_bound   = val[2:0];
        CFG_OWN_ID:        regs.own_id        = val;
        CFG_TRACKED_COUNT: regs.tracked_count = val;
        CFG_BLOCK_COUNT:   regs.block_count   = val;
        default: ;
      endcase
    endfunction

    function int unsigned node_limit();
      return (regs.node_count > PEERS) ? PEERS : regs.node_count;
    endfunction

    function int unsigned part_limit();
      return (regs.block_count > PARTS) ? PARTS : regs.block_count;
    endfunction

    function int unsigned quorum_size();
      int unsigned n;
      n = node_limit();
      return (n > regs.fault_bound) ? n - regs.fault_bound : 0;
    endfunction

    function bit [7:0] own_bit();
      if (regs.own_id >= 1 && regs.own_id <= PEERS)
        return 8'b1 << (regs.own_id - 1);
      return '0;
    endfunction

    function bit [3:0] bump(bit [3:0] v, int unsigned d);
      int unsigned s;
      s = v + d;
      return 4'((s > TALLY_TOP) ? TALLY_TOP : s);
    endfunction

    // one more ready vote for proposer k; deliver on reaching quorum
    function void add_ready(int unsigned k);
      ready_tally[k] = bump(ready_tally[k], 1);
      if (ready_tally[k] >= quorum_size() && !done_map[k]) begin
        done_map[k] = 1'b1;
        delivered   = bump(delivered, 1);
      end
    endfunction

    // Apply one message transfer and queue the status it produces.
    function void take_message(msg_t m);
      int unsigned n_eff, d_eff, nb, q, s, k;
      bit [7:0]    om, ef, eq, rq;
      result_t     r;
      n_eff = node_limit();
      d_eff = (regs.tracked_count > PEERS) ? PEERS : regs.tracked_count;
      nb    = part_limit();
      om    = own_bit();
      eq    = '0;
      rq    = '0;
      r     = '0;
      r.accepted = (m.sender_id != 0 && m.sender_id <= n_eff && m.signature_ok);
      if (r.accepted) begin
        s = m.sender_id - 1;
        r.want_init_reply = (om != 0 && regs.own_id <= regs.tracked_count &&
                             (m.init_ack_bits & om) == 0);
        if (m.command == CMD_INIT) begin
          if (m.block_index < nb && !parts_seen[s][m.block_index]) begin
            parts_seen[s][m.block_index] = 1'b1;
            parts_got[s] = parts_got[s] + 4'd1;
            if (parts_got[s] == nb) begin
              init_map[s]     = 1'b1;
              echo_map[s]     = 1'b1;
              echo_tally[s]   = bump(echo_tally[s], ECHO_BONUS);
              echo_from[s][s] = 1'b1;
            end
          end
        end else begin
          ef = echo_map | om;
          for (k = 0; k < d_eff; k++)
            if ((!m.echo_ack_bits[k] && ef[k]) || (!m.ready_ack_bits[k] && ready_map[k]))
              r.want_er_reply = 1'b1;
          for (k = 0; k < d_eff; k++) begin
            if (m.digest_match_bits[k]) begin
              if (m.echo_vote_bits[k] && !echo_from[k][s]) begin
                echo_from[k][s] = 1'b1;
                echo_tally[k]   = bump(echo_tally[k], 1);
                if (echo_tally[k] >= quorum_size() && !ready_map[k]) begin
                  ready_map[k] = 1'b1;
                  add_ready(k);
                end
              end
              if (m.ready_vote_bits[k] && !ready_from[k][s]) begin
                ready_from[k][s] = 1'b1;
                add_ready(k);
              end
            end
          end
        end
      end
      q = quorum_size();
      for (k = 0; k < n_eff; k++) begin
        eq[k] = (echo_tally[k] >= q);
        rq[k] = (ready_tally[k] >= q);
      end
      r.init_flags         = init_map | om;
      r.echo_flags         = echo_map | om;
      r.ready_flags        = ready_map;
      r.echo_quorum_flags  = eq;
      r.ready_quorum_flags = rq;
      r.done_flags         = done_map;
      r.done_total         = delivered;
      r.all_tracked_done   = (delivered == regs.tracked_count);
      status_due.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf({"acc=%b wi=%b wer=%b init=%h echo=%h ready=%h eq=%h rq=%h ",
                        "done=%h total=%0d all=%b"},
                       r.accepted, r.want_init_reply, r.want_er_reply, r.init_flags,
                       r.echo_flags, r.ready_flags, r.echo_quorum_flags,
                       r.ready_quorum_flags, r.done_flags, r.done_total,
                       r.all_tracked_done);
    endfunction

    function void flag_error(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("ERROR at %0t: %s", $time, what);
    endfunction

    // Compare one status transfer with the oldest prediction.
    function void check_status(logic [55:0] bus);
      result_t got, want;
      string   bad;
      got.accepted           = bus[0];
      got.want_init_reply    = bus[1];
      got.want_er_reply      = bus[2];
      got.init_flags         = bus[10:3];
      got.echo_flags         = bus[18:11];
      got.ready_flags        = bus[26:19];
      got.echo_quorum_flags  = bus[34:27];
      got.ready_quorum_flags = bus[42:35];
      got.done_flags         = bus[50:43];
      got.done_total         = bus[54:51];
      got.all_tracked_done   = bus[55];
      status_seen++;
      if (status_due.size() == 0) begin
        flag_error({"status with no message outstanding: ", show(got)});
        return;
      end
      want = status_due.pop_front();
      bad  = "";
      if (got.accepted !== want.accepted)                     bad = {bad, " accepted"};
      if (got.want_init_reply !== want.want_init_reply)       bad = {bad, " want_init_reply"};
      if (got.want_er_reply !== want.want_er_reply)           bad = {bad, " want_er_reply"};
      if (got.init_flags !== want.init_flags)                 bad = {bad, " init_flags"};
      if (got.echo_flags !== want.echo_flags)                 bad = {bad, " echo_flags"};
      if (got.ready_flags !== want.ready_flags)               bad = {bad, " ready_flags"};
      if (got.echo_quorum_flags !== want.echo_quorum_flags)   bad = {bad, " echo_quorum_flags"};
      if (got.ready_quorum_flags !== want.ready_quorum_flags) bad = {bad, " ready_quorum_flags"};
      if (got.done_flags !== want.done_flags)                 bad = {bad, " done_flags"};
      if (got.done_total !== want.done_total)                 bad = {bad, " done_total"};
      if (got.all_tracked_done !== want.all_tracked_done)     bad = {bad, " all_tracked_done"};
      if (bad != "")
        flag_error($sformatf("status %0d differs in%s\n  exp %s\n  act %s",
                             status_seen, bad, show(want), show(got)));
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the broadcast quorum tracker: a directed run over the reject,
// block and vote cases, then random phases under several register settings.
// Every status transfer is checked against the scoreboard's prediction, with
// random gaps and stalls on both streams outside phases 5 and 7, and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
  import bqt_pkg::*;
  import quorum_check_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 133;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;

  quorum_scoreboard sb;
  bit gaps_on;
  bit hold_long;
  bit hold_done;
  int quiet_cycles;

  broadcast_quorum_tracker_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic msg_t mk(logic cmd, logic [3:0] sender, logic sig, logic [2:0] blk,
                              logic [7:0] ia, logic [7:0] ea, logic [7:0] ev,
                              logic [7:0] ra, logic [7:0] rv, logic [7:0] dg);
    msg_t m;
    m.command           = cmd;
    m.sender_id         = sender;
    m.signature_ok      = sig;
    m.block_index       = blk;
    m.init_ack_bits     = ia;
    m.echo_ack_bits     = ea;
    m.echo_vote_bits    = ev;
    m.ready_ack_bits    = ra;
    m.ready_vote_bits   = rv;
    m.digest_match_bits = dg;
    return m;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with tvalid still high, so the caller drives the next item or drops it.
  task automatic push_msg(input msg_t m);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m.command;
    s_tdata  <= {m.digest_match_bits, m.ready_vote_bits, m.ready_ack_bits,
                 m.echo_vote_bits, m.echo_ack_bits, m.init_ack_bits,
                 m.block_index, m.signature_ok, m.sender_id};
    do @(posedge clk); while (!s_tready);
    sb.take_message(m);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [3:0] n, input logic [3:0] f,
                              input logic [3:0] own, input logic [3:0] d,
                              input logic [3:0] parts);
    logic [2:0] idx [5];
    logic [3:0] val [5];
    idx = '{CFG_NODE_COUNT, CFG_FAULT_BOUND, CFG_OWN_ID, CFG_TRACKED_COUNT,
            CFG_BLOCK_COUNT};
    val = '{n, f, own, d, parts};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // wait for every outstanding status, then let the pipeline drain
  task automatic settle();
    while (sb.status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly valid senders with sparse votes so quorums build up slowly;
  // about one in ten items is pure noise.
  task automatic run_random(input int count, input bit squeeze);
    msg_t        m;
    bit [63:0]   raw;
    int unsigned n_eff, nb;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == 20) hold_long = 1'b1;
      n_eff = sb.node_limit();
      nb    = sb.part_limit();
      raw   = {$urandom, $urandom};
      m     = raw[56:0];
      if ($urandom_range(0, 9) != 0) begin
        m.sender_id    = (n_eff == 0) ? 4'($urandom_range(1, 15))
                                      : 4'($urandom_range(1, n_eff));
        m.signature_ok = ($urandom_range(0, 19) != 0);
        m.command      = ($urandom_range(0, 4) < 2) ? CMD_INIT : CMD_ECHO_READY;
        if (nb > 0 && $urandom_range(0, 9) != 0)
          m.block_index = 3'($urandom_range(0, nb - 1));
        m.echo_ack_bits     = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        m.ready_ack_bits    = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        m.echo_vote_bits    = 8'($urandom & $urandom);
        m.ready_vote_bits   = 8'($urandom & $urandom);
        m.digest_match_bits = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
      end
      push_msg(m);
    end
  endtask

  // result side: random stalls, and one long hold on request
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_long && !hold_done) begin
        m_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_status(m_tdata);
  end

  // end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    gaps_on      = 1'b1;
    hold_long    = 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings N=4, f=1, own id 1, three tracked, one block
    push_msg(mk(CMD_INIT, 4'd0, 1'b1, 3'd0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF));
    push_msg(mk(CMD_INIT, 4'd5, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_ECHO_READY, 4'd15, 1'b1, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_msg(mk(CMD_INIT, 4'd2, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_INIT, 4'd2, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_INIT, 4'd2, 1'b1, 3'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_INIT, 4'd3, 1'b1, 3'd5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_INIT, 4'd3, 1'b1, 3'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_ECHO_READY, 4'd1, 1'b1, 3'd0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF));
    push_msg(mk(CMD_ECHO_READY, 4'd4, 1'b1, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    push_msg(mk(CMD_ECHO_READY, 4'd4, 1'b1, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_msg(mk(CMD_ECHO_READY, 4'd3, 1'b1, 3'd0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF));
    push_msg(mk(CMD_ECHO_READY, 4'd2, 1'b1, 3'd0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_msg(mk(CMD_ECHO_READY, 4'd1, 1'b1, 3'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF));
    push_msg(mk(CMD_ECHO_READY, 4'd4, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_msg(mk(CMD_INIT, 4'd4, 1'b1, 3'd7, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_msg(mk(CMD_INIT, 4'd1, 1'b1, 3'd0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    s_tvalid <= 1'b0;
    settle();

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: program_regs(4'd8, 4'd0, 4'd8, 4'd8, 4'd8);
        2: program_regs(4'd1, 4'd7, 4'd1, 4'd1, 4'd1);
        3: program_regs(4'd15, 4'd3, 4'd0, 4'd15, 4'd15);
        7: program_regs(4'd8, 4'd2, 4'd5, 4'd8, 4'd2);
        default: program_regs(4'($urandom_range(1, 8)), 4'($urandom_range(0, 7)),
                              4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                              4'($urandom_range(1, 3)));
      endcase
      gaps_on = (p != 5 && p != 7);
      run_random(PHASE_ITEMS, p == 3);
      s_tvalid <= 1'b0;
      if (p != 7) settle();
    end

    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
